FILE: rtl/core/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the 2D correlation core
// Register indexes, opcodes, field widths and small helper functions.
// ----------------------------------------------------------------------------
package swc_pkg;

    // Defaults of the top level parameters.
    localparam int MAX_RADIUS_DEF     = 3;
    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEFF_WIDTH_DEF    = 16;

    // Fixed field widths.
    localparam int RADIUS_W   = 2;
    localparam int LINE_CFG_W = 11;
    localparam int ROWS_W     = 16;
    localparam int CIDX_W     = 6;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Output saturation limits.
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 2'd2;

    // Opcodes of an input beat.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Index width for a store of n entries, at least one bit.
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Row of a row-major mask position, found by independent compares.
    function automatic int unsigned mask_row(input int unsigned idx, input int unsigned side);
        int unsigned q;
        q = 0;
        for (int unsigned i = 1; i < 16; i++) begin
            if (i < side && idx >= i * side) begin
                q = i;
            end
        end
        return q;
    endfunction

endpackage

FILE: rtl/core/swc_if.sv
// ----------------------------------------------------------------------------
// swc_if: channel interfaces of the 2D correlation core
// Input item stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface swc_in_if #(
    parameter int SAMPLE_WIDTH = swc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_WIDTH  = swc_pkg::COEFF_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic                           frame_start;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [swc_pkg::CIDX_W-1:0]     coeff_index;
    logic [COEFF_WIDTH-1:0]         coeff_value;

    modport source (output valid, opcode, frame_start, sample, coeff_index, coeff_value,
                    input ready);
    modport sink   (input valid, opcode, frame_start, sample, coeff_index, coeff_value,
                    output ready);
endinterface

interface swc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [swc_pkg::OUT_W-1:0]  field_value;
    logic                              last_of_frame;

    modport source (output valid, field_value, last_of_frame, input ready);
    modport sink   (input valid, field_value, last_of_frame, output ready);
endinterface

interface swc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [swc_pkg::CFG_IDX_W-1:0]    index;
    logic [swc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/swc_ram.sv
// ----------------------------------------------------------------------------
// swc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swc_ram import swc_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [idx_w(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic [idx_w(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/swc_front.sv
// ----------------------------------------------------------------------------
// swc_front: item intake and classification
// Holds the configuration registers and the raster counters, decides for
// each sample whether it completes a window, and queues commands.
// ----------------------------------------------------------------------------
module swc_front import swc_pkg::*; #(
    parameter int  MAX_RADIUS     = MAX_RADIUS_DEF,
    parameter int  MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int  SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int  COEFF_WIDTH    = COEFF_WIDTH_DEF,
    parameter type t_cmd          = logic
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    swc_in_if.sink   i_in,
    swc_cfg_if.sink  i_cfg,
    output t_cmd     o_cmd,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready
);
    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = idx_w(SIDE);
    localparam int COL_W  = idx_w(MAX_LINE_WIDTH);
    localparam int LW_W   = $clog2(MAX_LINE_WIDTH + 1);
    localparam int ROW_W  = ROWS_W + 1;

    // Configuration registers.
    logic [RADIUS_W-1:0]   r_radius;
    logic [LINE_CFG_W-1:0] r_line;
    logic [ROWS_W-1:0]     r_rows;

    // Raster position of the next sample.
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [COL_W-1:0]  r_col,  n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;

    // Two-entry command queue.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic              accept, pop;
    logic [LW_W-1:0]   w;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] two_r;
    logic              emit, last;
    int unsigned       crow;
    t_cmd              cmd;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_cnt != 2'd2);
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(1);
            r_line   <= LINE_CFG_W'(1024);
            r_rows   <= ROWS_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RADIUS:     r_radius <= i_cfg.data[RADIUS_W-1:0];
                REG_LINE_WIDTH: r_line   <= i_cfg.data[LINE_CFG_W-1:0];
                REG_OUT_ROWS:   r_rows   <= i_cfg.data[ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective line width, clamped to the line store.
    always_comb begin
        if (r_line == '0) begin
            w = LW_W'(1);
        end else if (32'(r_line) > 32'(MAX_LINE_WIDTH)) begin
            w = LW_W'(MAX_LINE_WIDTH);
        end else begin
            w = LW_W'(r_line);
        end
    end

    // Classify the incoming beat and work out the next raster position.
    always_comb begin
        two_r = SLOT_W'({r_radius, 1'b0});
        if (i_in.frame_start) begin
            row  = '0;
            col  = '0;
            slot = '0;
        end else begin
            row  = r_row;
            col  = r_col;
            slot = r_slot;
        end

        emit = (32'(row) >= 32'(two_r)) && (32'(col) >= 32'(two_r)) &&
               (32'(col) < 32'(w)) && (32'(row) - 32'(two_r) < 32'(r_rows));
        last = (32'(row) - 32'(two_r) == 32'(r_rows) - 32'd1) &&
               (32'(col) == 32'(w) - 32'd1);

        n_row  = row;
        n_col  = col;
        n_slot = slot;
        if (32'(col) + 32'd1 >= 32'(w)) begin
            n_col  = '0;
            n_slot = (32'(slot) == SIDE - 1) ? '0 : SLOT_W'(32'(slot) + 32'd1);
            if (32'(row) < 32'(r_rows) + 32'(two_r)) begin
                n_row = ROW_W'(32'(row) + 32'd1);
            end
        end else begin
            n_col = COL_W'(32'(col) + 32'd1);
        end

        crow            = mask_row(32'(i_in.coeff_index), SIDE);
        cmd.op          = i_in.opcode;
        cmd.sample      = i_in.sample;
        cmd.col         = col;
        cmd.slot        = slot;
        cmd.two_r       = two_r;
        cmd.emit        = emit;
        cmd.last        = last;
        cmd.cload       = (32'(i_in.coeff_index) < SIDE * SIDE);
        cmd.caddr       = SLOT_W'(crow);
        cmd.cbank       = SLOT_W'(32'(i_in.coeff_index) - crow * SIDE);
        cmd.cval        = i_in.coeff_value;
    end

    // Raster counters advance on every accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (accept && i_in.opcode == OP_SAMPLE) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({accept, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd;
        end
    end
endmodule

FILE: rtl/core/swc_back.sv
// ----------------------------------------------------------------------------
// swc_back: line store, window registers and multiply-accumulate
// Executes queued commands: coefficient loads, sample writes with a window
// column shift, and a row-by-row correlation sum with rounding.
// ----------------------------------------------------------------------------
module swc_back import swc_pkg::*; #(
    parameter int  MAX_RADIUS     = MAX_RADIUS_DEF,
    parameter int  MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int  SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int  COEFF_WIDTH    = COEFF_WIDTH_DEF,
    parameter type t_cmd          = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    swc_out_if.source o_out
);
    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = idx_w(SIDE);
    localparam int CNT_W  = idx_w(SIDE + 1);
    localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH + 1;
    localparam int ACC_W  = PROD_W + $clog2(SIDE * SIDE + 1);
    localparam int RND_W  = ACC_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COL  = 4'b0010,
        ST_MAC  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   pop;

    logic signed [SAMPLE_WIDTH-1:0] r_win [SIDE][SIDE];
    logic [SAMPLE_WIDTH-1:0]        line_rd [SIDE];
    logic [COEFF_WIDTH-1:0]         coef_rd [SIDE];
    logic [SLOT_W-1:0]              coef_raddr;

    logic [CNT_W-1:0]         r_ci;
    logic                     r_cv, r_pv;
    logic [CNT_W-1:0]         r_cim;
    logic signed [PROD_W-1:0] r_prod [SIDE];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  row_sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [OUT_W-1:0]  sat;
    logic                     mac_done;

    logic                     r_ov;
    logic signed [OUT_W-1:0]  r_fv;
    logic                     r_lf;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign coef_raddr  = SLOT_W'(r_ci);

    // One line store bank per slot, all read at the same column.
    for (genvar b = 0; b < SIDE; b++) begin : g_line
        swc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_LINE_WIDTH)) u_line (
            .i_clk   (i_clk),
            .i_we    (pop && i_cmd.op == OP_SAMPLE && 32'(i_cmd.slot) == b),
            .i_waddr (i_cmd.col),
            .i_wdata (i_cmd.sample),
            .i_raddr (i_cmd.col),
            .o_rdata (line_rd[b])
        );
    end

    // One coefficient bank per mask column, addressed by mask row.
    for (genvar b = 0; b < SIDE; b++) begin : g_coef
        swc_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(SIDE)) u_coef (
            .i_clk   (i_clk),
            .i_we    (pop && i_cmd.op == OP_LOAD && i_cmd.cload &&
                      32'(i_cmd.cbank) == b),
            .i_waddr (i_cmd.caddr),
            .i_wdata (i_cmd.cval),
            .i_raddr (coef_raddr),
            .o_rdata (coef_rd[b])
        );
    end

    // Sum of one mask row of products.
    always_comb begin
        row_sum = '0;
        for (int j = 0; j < SIDE; j++) begin
            row_sum = row_sum + ACC_W'(r_prod[j]);
        end
    end

    assign mac_done = (32'(r_ci) > 32'(r_cmd.two_r)) && !r_cv && !r_pv;

    // Round half up from the accumulator scale and saturate.
    always_comb begin
        rnd = (RND_W'(r_acc) + RND_W'(1 << (COEFF_WIDTH - 1))) >>> COEFF_WIDTH;
        if (rnd > RND_W'(OUT_MAX)) begin
            sat = OUT_W'(OUT_MAX);
        end else if (rnd < RND_W'(OUT_MIN)) begin
            sat = OUT_W'(OUT_MIN);
        end else begin
            sat = OUT_W'(rnd);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ci    <= '0;
            r_cv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (pop && i_cmd.op == OP_SAMPLE) begin
                        r_state <= ST_COL;
                    end
                end
                ST_COL: begin
                    r_ci <= '0;
                    r_cv <= 1'b0;
                    r_pv <= 1'b0;
                    r_state <= r_cmd.emit ? ST_MAC : ST_IDLE;
                end
                ST_MAC: begin
                    if (32'(r_ci) <= 32'(r_cmd.two_r)) begin
                        r_ci <= r_ci + CNT_W'(1);
                        r_cv <= 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    r_pv <= r_cv;
                    if (mac_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ov) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Command latch and mask row tracking.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_MAC) begin
            r_cim <= r_ci;
        end
    end

    // Window registers: a new column enters on every sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE; k++) begin
                for (int d = 0; d < SIDE; d++) begin
                    r_win[k][d] <= '0;
                end
            end
        end else if (r_state == ST_COL) begin
            for (int k = 0; k < SIDE; k++) begin
                for (int d = SIDE - 1; d > 0; d--) begin
                    r_win[k][d] <= r_win[k][d-1];
                end
                if (k == 0) begin
                    r_win[k][0] <= r_cmd.sample;
                end else if (32'(r_cmd.slot) >= k) begin
                    r_win[k][0] <= line_rd[SLOT_W'(32'(r_cmd.slot) - k)];
                end else begin
                    r_win[k][0] <= line_rd[SLOT_W'(32'(r_cmd.slot) + SIDE - k)];
                end
            end
        end
    end

    // Products of one mask row, then accumulation.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COL) begin
            r_acc <= '0;
        end else if (r_state == ST_MAC) begin
            if (r_cv) begin
                for (int j = 0; j < SIDE; j++) begin
                    if (j <= 32'(r_cmd.two_r)) begin
                        r_prod[j] <= PROD_W'(
                            r_win[SLOT_W'(32'(r_cmd.two_r) - 32'(r_cim))]
                                 [SLOT_W'(32'(r_cmd.two_r) - j)] *
                            $signed({1'b0, coef_rd[j]}));
                    end else begin
                        r_prod[j] <= '0;
                    end
                end
            end
            if (r_pv) begin
                r_acc <= r_acc + row_sum;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_OUT && !r_ov) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && !r_ov) begin
            r_fv <= sat;
            r_lf <= r_cmd.last;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.field_value   = r_fv;
    assign o_out.last_of_frame = r_lf;
endmodule

FILE: rtl/core/sliding_window_2d_correlation_core.sv
// ----------------------------------------------------------------------------
// sliding_window_2d_correlation_core: 2D correlation over a streamed grid
// Top level: intake and classification, command queue, execution unit.
// ----------------------------------------------------------------------------
// A coefficient load is written to its bank as the queue hands it over. A sample
// that completes no window goes through a line store read and a window column
// shift. A sample that completes a window goes on from there: the mask is worked
// one row per cycle through 2*MAX_RADIUS+1 multipliers, then a short drain,
// rounding and the output register. A two-entry queue sits between intake and
// execution, and results wait in an output register. Line and coefficient
// stores need no clearing pass after reset.
module sliding_window_2d_correlation_core import swc_pkg::*; #(
    parameter int MAX_RADIUS     = MAX_RADIUS_DEF,
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEFF_WIDTH    = COEFF_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swc_in_if.sink    i_in,
    swc_cfg_if.sink   i_cfg,
    swc_out_if.source o_out
);
    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = idx_w(SIDE);
    localparam int COL_W  = idx_w(MAX_LINE_WIDTH);

    // Command from intake to execution.
    typedef struct packed {
        logic                           op;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [COL_W-1:0]               col;
        logic [SLOT_W-1:0]              slot;
        logic [SLOT_W-1:0]              two_r;
        logic                           emit;
        logic                           last;
        logic                           cload;
        logic [SLOT_W-1:0]              caddr;
        logic [SLOT_W-1:0]              cbank;
        logic [COEFF_WIDTH-1:0]         cval;
    } t_cmd;

    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    swc_front #(
        .MAX_RADIUS     (MAX_RADIUS),
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEFF_WIDTH    (COEFF_WIDTH),
        .t_cmd          (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    swc_back #(
        .MAX_RADIUS     (MAX_RADIUS),
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEFF_WIDTH    (COEFF_WIDTH),
        .t_cmd          (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out)
    );
endmodule

FILE: rtl/core/swc_checker.sv
// ----------------------------------------------------------------------------
// swc_checker: port-level checks of the 2D correlation core
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module swc_checker import swc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    cfg_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] out_field,
    input logic                    out_last
);
    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // A stalled result holds its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_field) && $stable(out_last))
        else $error("stalled result changed");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) cfg_ready)
        else $error("configuration channel stalled");

    // Intake stops only when an accepted beat has filled the queue.
    a_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("intake stalled without an accepted beat");
endmodule

bind sliding_window_2d_correlation_core swc_checker u_swc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .cfg_ready (i_cfg.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_field (o_out.field_value),
    .out_last  (o_out.last_of_frame)
);
